### hw/rtl/ymts_pkg.sv
package ymts_pkg;

  // field widths
  localparam int YEAR_W     = 12;
  localparam int MONTH_W    = 4;
  localparam int TEMP_W     = 10;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 20;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 3;

  localparam int MONTHS_PER_YEAR = 12;
  localparam int DEF_YEAR_SLOTS  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_MONTH = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  // running statistics record, as held in the stat memories
  typedef struct packed {
    logic signed [TEMP_W-1:0] tmin;
    logic signed [TEMP_W-1:0] tmax;
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         count;
  } stat_rec_t;

  // key table lookup outcome
  typedef struct packed {
    logic hit;
    logic full;
  } lookup_t;

endpackage

### hw/rtl/ymts_key_table.sv
module ymts_key_table #(
  parameter int YEAR_SLOTS = ymts_pkg::DEF_YEAR_SLOTS,
  parameter int SLOT_W     = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ymts_pkg::YEAR_W-1:0] key,
  input  logic                        alloc,
  output ymts_pkg::lookup_t           res,
  output logic [SLOT_W-1:0]           slot
);
  import ymts_pkg::*;

  logic [YEAR_SLOTS-1:0] valid;
  logic [YEAR_W-1:0]     keys [YEAR_SLOTS];

  logic              hit;
  logic              free_found;
  logic [SLOT_W-1:0] slot_hit;
  logic [SLOT_W-1:0] slot_free;

  // first matching slot and first free slot
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    slot_hit   = '0;
    slot_free  = '0;
    for (int i = 0; i < YEAR_SLOTS; i++) begin
      if (valid[i]) begin
        if (!hit && keys[i] == key) begin
          hit      = 1'b1;
          slot_hit = SLOT_W'(i);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        slot_free  = SLOT_W'(i);
      end
    end
  end

  assign slot     = hit ? slot_hit : slot_free;
  assign res.hit  = hit;
  assign res.full = !hit && !free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (alloc) begin
      valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      keys[slot] <= key;
    end
  end

endmodule

### hw/rtl/ymts_rec_update.sv
module ymts_rec_update (
  input  ymts_pkg::stat_rec_t                old_rec,
  input  logic                               fresh,
  input  logic signed [ymts_pkg::TEMP_W-1:0] temp,
  output ymts_pkg::stat_rec_t                new_rec
);
  import ymts_pkg::*;

  logic signed [SUM_W:0] sum_wide;

  // one guard bit is enough to spot overflow of a single add
  assign sum_wide = {old_rec.sum[SUM_W-1], old_rec.sum} + (SUM_W+1)'(temp);

  always_comb begin
    if (fresh) begin
      new_rec.tmin  = temp;
      new_rec.tmax  = temp;
      new_rec.sum   = SUM_W'(temp);
      new_rec.count = CNT_W'(1);
    end else begin
      new_rec.tmin = ($signed(temp) < $signed(old_rec.tmin)) ? temp : old_rec.tmin;
      new_rec.tmax = ($signed(temp) > $signed(old_rec.tmax)) ? temp : old_rec.tmax;
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        new_rec.sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        new_rec.sum = sum_wide[SUM_W-1:0];
      end
      new_rec.count = (old_rec.count == CNT_MAX) ? old_rec.count : old_rec.count + 1'b1;
    end
  end

endmodule

### hw/rtl/yearly_monthly_temp_stats.sv
// channel   direction  handshake         fields
// request   in         start / busy      sample_year, sample_month, temperature
// result    out        done (one cycle)  status, slot_index, year_*, month_*
//
// a request is taken at an edge with start high and busy low; the result
// registers load at the next edge and hold the result for the single cycle
// that done is high. a request is a read of the year and month records,
// then the write back; busy stays high until it is done. after reset busy
// stays high while every month record in the month memory is swept clear.
// the receiver cannot stall; results are never held back.
module yearly_monthly_temp_stats #(
  parameter int YEAR_SLOTS = ymts_pkg::DEF_YEAR_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ymts_pkg::YEAR_W-1:0]           sample_year,
  input  logic [ymts_pkg::MONTH_W-1:0]          sample_month,
  input  logic signed [ymts_pkg::TEMP_W-1:0]    temperature,
  output logic                                  done,
  output logic [ymts_pkg::STATUS_W-1:0]         status,
  output logic [ymts_pkg::SLOT_IDX_W-1:0]       slot_index,
  output logic signed [ymts_pkg::TEMP_W-1:0]    year_min,
  output logic signed [ymts_pkg::TEMP_W-1:0]    year_max,
  output logic signed [ymts_pkg::SUM_W-1:0]     year_sum,
  output logic [ymts_pkg::CNT_W-1:0]            year_count,
  output logic signed [ymts_pkg::TEMP_W-1:0]    month_min,
  output logic signed [ymts_pkg::TEMP_W-1:0]    month_max,
  output logic signed [ymts_pkg::SUM_W-1:0]     month_sum,
  output logic [ymts_pkg::CNT_W-1:0]            month_count
);
  import ymts_pkg::*;

  localparam int SLOT_W      = (YEAR_SLOTS > 1) ? $clog2(YEAR_SLOTS) : 1;
  localparam int MONTH_DEPTH = YEAR_SLOTS * MONTHS_PER_YEAR;
  localparam int MADDR_W     = $clog2(MONTH_DEPTH);

  // control states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_RMW  = 1'b1;

  logic state;
  logic state_next;

  // clearing sweep of the month memory after reset
  logic               clr_active;
  logic [MADDR_W-1:0] clr_addr;

  logic accept;
  logic month_ok;

  lookup_t           kt_res;
  logic [SLOT_W-1:0] kt_slot;
  logic              alloc;

  logic [MADDR_W-1:0] maddr;

  // request held across the read cycle
  logic signed [TEMP_W-1:0] temp_q;
  logic [STATUS_W-1:0]      status_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [MADDR_W-1:0]       maddr_q;
  logic                     new_year_q;

  // record memories
  stat_rec_t year_mem  [YEAR_SLOTS];
  stat_rec_t month_mem [MONTH_DEPTH];
  stat_rec_t year_rd;
  stat_rec_t month_rd;
  stat_rec_t year_new;
  stat_rec_t month_new;

  logic               month_we;
  logic [MADDR_W-1:0] month_waddr;
  stat_rec_t          month_wdata;
  logic               year_we;

  assign busy     = clr_active || (state == S_RMW);
  assign accept   = start && !busy;
  assign month_ok = (sample_month != '0) &&
                    (sample_month <= MONTH_W'(MONTHS_PER_YEAR));

  ymts_key_table #(
    .YEAR_SLOTS(YEAR_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_key_table (
    .clk  (clk),
    .rst  (rst),
    .key  (sample_year),
    .alloc(alloc),
    .res  (kt_res),
    .slot (kt_slot)
  );

  // a new year takes its slot at once; its months are still clear from the sweep
  assign alloc = accept && month_ok && !kt_res.hit && !kt_res.full;

  // month record address: slot * 12 + month - 1
  assign maddr = MADDR_W'(MADDR_W'(kt_slot) * MADDR_W'(MONTHS_PER_YEAR))
               + MADDR_W'(sample_month) - MADDR_W'(1);

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = accept ? S_RMW : S_IDLE;
      S_RMW:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      state <= state_next;
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == MADDR_W'(MONTH_DEPTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      temp_q     <= temperature;
      slot_q     <= kt_slot;
      maddr_q    <= maddr;
      new_year_q <= !kt_res.hit;
      if (!month_ok) begin
        status_q <= STAT_BAD_MONTH;
      end else if (kt_res.full) begin
        status_q <= STAT_FULL;
      end else begin
        status_q <= STAT_OK;
      end
    end
  end

  // year memory: read at request, written back in the following cycle
  assign year_we = (state == S_RMW) && (status_q == STAT_OK);

  always_ff @(posedge clk) begin
    if (year_we) begin
      year_mem[slot_q] <= year_new;
    end
    if (accept) begin
      year_rd <= year_mem[kt_slot];
    end
  end

  // month memory: one write port shared by the sweep and the write back
  assign month_we    = clr_active || ((state == S_RMW) && (status_q == STAT_OK));
  assign month_waddr = clr_active ? clr_addr : maddr_q;
  assign month_wdata = clr_active ? '0 : month_new;

  always_ff @(posedge clk) begin
    if (month_we) begin
      month_mem[month_waddr] <= month_wdata;
    end
    if (accept && month_ok) begin
      month_rd <= month_mem[maddr];
    end
  end

  ymts_rec_update u_year_upd (
    .old_rec(year_rd),
    .fresh  (new_year_q),
    .temp   (temp_q),
    .new_rec(year_new)
  );

  // a zero count marks a month with no samples yet
  ymts_rec_update u_month_upd (
    .old_rec(month_rd),
    .fresh  (month_rd.count == '0),
    .temp   (temp_q),
    .new_rec(month_new)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_RMW);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RMW) begin
      status <= status_q;
      if (status_q == STAT_OK) begin
        slot_index  <= SLOT_IDX_W'(slot_q);
        year_min    <= year_new.tmin;
        year_max    <= year_new.tmax;
        year_sum    <= year_new.sum;
        year_count  <= year_new.count;
        month_min   <= month_new.tmin;
        month_max   <= month_new.tmax;
        month_sum   <= month_new.sum;
        month_count <= month_new.count;
      end else begin
        slot_index  <= '0;
        year_min    <= '0;
        year_max    <= '0;
        year_sum    <= '0;
        year_count  <= '0;
        month_min   <= '0;
        month_max   <= '0;
        month_sum   <= '0;
        month_count <= '0;
      end
    end
  end

  // a result only ever follows a write-back cycle
  a_done_after_rmw: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RMW))
    else $error("result strobe without a write-back cycle");

  // a taken request always moves to the write-back cycle
  a_accept_to_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RMW))
    else $error("request taken but no write-back followed");

  // rejected requests carry no statistics
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (year_count == '0 && month_count == '0))
    else $error("rejected request reported statistics");

  // a month never holds more samples than its year
  a_month_le_year: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_OK) |-> (month_count != '0 && year_count >= month_count))
    else $error("month count inconsistent with year count");

endmodule
